// ===== hdl/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue package
// Shared payload types, mode and status codes, and the command and status
// groups that join the controller and the datapath.
// ----------------------------------------------------------------------------
package deq_pkg;

  // Request modes.
  localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [2:0] MODE_PUSH_REAR  = 3'd1;
  localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [2:0] MODE_POP_REAR   = 3'd3;
  localparam logic [2:0] MODE_LIST       = 3'd4;

  // Result status codes.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  // Input request payload.
  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] push_value;
  } in_t;

  // Result payload.
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] out_value;
    logic               last;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       push_front;
    logic       push_rear;
    logic       pop_front;
    logic       pop_rear;
    logic       list_start;
    logic       list_next;
    logic       ld_imm;
    logic       ld_mem;
    logic [1:0] imm_status;
  } deq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
    logic out_last;
  } deq_sts_t;

endpackage

// ===== hdl/deq_dpath.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue datapath
// Ring memory with front index and element count, read data register,
// list index and the result register.
// ----------------------------------------------------------------------------
module deq_dpath #(
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  deq_pkg::deq_cmd_t cmd,
  input  logic signed [31:0] push_value,
  output deq_pkg::deq_sts_t sts,
  output deq_pkg::out_t    out_data
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

  logic signed [31:0] mem [DEPTH];

  logic [IW-1:0]      front_r, front_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic signed [31:0] rd_data_r;
  logic               rd_last_r, rd_last_nxt;
  deq_pkg::out_t      out_r;

  logic [IW-1:0]      front_dec, front_inc, rear_wr, rear_rd, list_addr;
  logic [CW-1:0]      idx_inc;
  logic               wr_en, rd_en;
  logic [IW-1:0]      wr_addr, rd_addr;

  // Fold a position below twice the depth back into the ring.
  function automatic logic [IW-1:0] wrap_idx(input logic [SW-1:0] pos);
    logic [SW-1:0] adj;
    adj = (pos >= DEPTH_S) ? pos - DEPTH_S : pos;
    return adj[IW-1:0];
  endfunction

  // Ring positions derived from the front index and the count.
  assign front_dec = (front_r == '0) ? LAST_IDX : front_r - IW'(1);
  assign front_inc = (front_r == LAST_IDX) ? '0 : front_r + IW'(1);
  assign rear_wr   = wrap_idx(SW'(front_r) + SW'(count_r));
  assign rear_rd   = wrap_idx(SW'(front_r) + SW'(count_r) - SW'(1));
  assign idx_inc   = idx_r + CW'(1);
  assign list_addr = wrap_idx(SW'(front_r) + SW'(idx_inc));

  // Memory port control.
  assign wr_en   = cmd.push_front | cmd.push_rear;
  assign wr_addr = cmd.push_front ? front_dec : rear_wr;
  assign rd_en   = cmd.pop_front | cmd.pop_rear | cmd.list_start | cmd.list_next;

  always_comb begin
    rd_addr = front_r;
    if (cmd.pop_rear) begin
      rd_addr = rear_rd;
    end else if (cmd.list_next) begin
      rd_addr = list_addr;
    end
  end

  // Next front, count, list index and last marker.
  always_comb begin
    front_nxt   = front_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    rd_last_nxt = rd_last_r;
    if (cmd.push_front) begin
      front_nxt = front_dec;
      count_nxt = count_r + CW'(1);
    end else if (cmd.push_rear) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.pop_front) begin
      front_nxt   = front_inc;
      count_nxt   = count_r - CW'(1);
      rd_last_nxt = 1'b1;
    end else if (cmd.pop_rear) begin
      count_nxt   = count_r - CW'(1);
      rd_last_nxt = 1'b1;
    end else if (cmd.list_start) begin
      idx_nxt     = '0;
      rd_last_nxt = (count_r == CW'(1));
    end else if (cmd.list_next) begin
      idx_nxt     = idx_inc;
      rd_last_nxt = ((idx_inc + CW'(1)) == count_r);
    end
  end

  // Pointer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      front_r <= front_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Ring memory with registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= push_value;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Read marker and result register.
  always_ff @(posedge clk) begin
    rd_last_r <= rd_last_nxt;
    if (cmd.ld_imm) begin
      out_r.status    <= cmd.imm_status;
      out_r.out_value <= '0;
      out_r.last      <= 1'b1;
    end else if (cmd.ld_mem) begin
      out_r.status    <= deq_pkg::STAT_OK;
      out_r.out_value <= rd_data_r;
      out_r.last      <= rd_last_r;
    end
  end

  assign out_data     = out_r;
  assign sts.empty    = (count_r == '0);
  assign sts.full     = (count_r == CW'(DEPTH));
  assign sts.out_last = out_r.last;

`ifndef NO_ASSERTIONS
  // The count never exceeds the ring size.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("element count above depth");

  // A push is only carried out when there is room.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push_front || cmd.push_rear) |-> !sts.full)
    else $error("push issued on a full ring");

  // A pop or a list start only happens when the ring holds elements.
  a_read_live: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.pop_front || cmd.pop_rear || cmd.list_start) |-> !sts.empty)
    else $error("read issued on an empty ring");

  // Each push grows the element count by exactly one step.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push_front || cmd.push_rear) |=> count_r == $past(count_r) + CW'(1))
    else $error("push did not grow the count by one");
`endif

endmodule

// ===== hdl/deq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue controller
// Decodes each request, sequences the memory read and result load, and
// steps through the ring for a list request.
// ----------------------------------------------------------------------------
module deq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        mode,
  output logic              out_valid,
  input  logic              out_ready,
  input  deq_pkg::deq_sts_t sts,
  output deq_pkg::deq_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SEND
  } state_t;

  state_t state_r, state_nxt;
  logic   lst_r, lst_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_SEND);

  // Command decode and next state.
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    lst_nxt   = lst_r;
    case (state_r)
      ST_IDLE: begin
        lst_nxt = 1'b0;
        if (in_valid) begin
          case (mode)
            deq_pkg::MODE_PUSH_FRONT, deq_pkg::MODE_PUSH_REAR: begin
              cmd.ld_imm = 1'b1;
              state_nxt  = ST_SEND;
              if (sts.full) begin
                cmd.imm_status = deq_pkg::STAT_FULL;
              end else begin
                cmd.imm_status = deq_pkg::STAT_OK;
                cmd.push_front = (mode == deq_pkg::MODE_PUSH_FRONT);
                cmd.push_rear  = (mode == deq_pkg::MODE_PUSH_REAR);
              end
            end
            deq_pkg::MODE_POP_FRONT, deq_pkg::MODE_POP_REAR: begin
              if (sts.empty) begin
                cmd.ld_imm     = 1'b1;
                cmd.imm_status = deq_pkg::STAT_EMPTY;
                state_nxt      = ST_SEND;
              end else begin
                cmd.pop_front = (mode == deq_pkg::MODE_POP_FRONT);
                cmd.pop_rear  = (mode == deq_pkg::MODE_POP_REAR);
                state_nxt     = ST_LOAD;
              end
            end
            deq_pkg::MODE_LIST: begin
              if (sts.empty) begin
                cmd.ld_imm     = 1'b1;
                cmd.imm_status = deq_pkg::STAT_EMPTY;
                state_nxt      = ST_SEND;
              end else begin
                cmd.list_start = 1'b1;
                lst_nxt        = 1'b1;
                state_nxt      = ST_LOAD;
              end
            end
            default: begin
              // Undefined modes are taken and dropped.
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_LOAD: begin
        cmd.ld_mem = 1'b1;
        state_nxt  = ST_SEND;
      end
      ST_SEND: begin
        if (out_ready) begin
          if (lst_r && !sts.out_last) begin
            cmd.list_next = 1'b1;
            state_nxt     = ST_LOAD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      lst_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      lst_r   <= lst_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // A result is never offered while a request can be taken.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  // A memory load is always followed by offering the result.
  a_load_send: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_mem |=> out_valid)
    else $error("loaded result not offered");

  // Further list reads happen only during a list request.
  a_list_flag: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.list_next |-> lst_r)
    else $error("list step outside a list request");
`endif

endmodule

// ===== hdl/double_ended_queue_unit.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue unit
// Deque of signed 32-bit values in a ring of DEPTH entries, with push and
// pop at both ends and an in-order list request.
//
//   Channel  Ports                          Carries
//   in       in_valid, in_ready, in_data    mode and push value (in_t)
//   out      out_valid, out_ready, out_data status, value, last (out_t)
//
// One request is handled at a time. A push or any error result goes straight
// to the result register; a pop goes through the registered ring read first.
// A list reads in order through the single memory read port, fetching each
// element once the last was taken. An undefined mode is taken with no result.
// Reset is synchronous and empties the deque; out_ready low holds the result.
// ----------------------------------------------------------------------------
module double_ended_queue_unit #(
  parameter int DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  deq_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output deq_pkg::out_t out_data
);

  deq_pkg::deq_cmd_t cmd;
  deq_pkg::deq_sts_t sts;

  // Request sequencing.
  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (in_data.mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Ring storage and result register.
  deq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .push_value (in_data.push_value),
    .sts        (sts),
    .out_data   (out_data)
  );

endmodule

// ===== verif/double_ended_queue_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue unit testbench
// Sends push, pop and list requests through a backlog-fed driver and checks
// every result against a deque predictor kept in the bench. Directed requests
// cover the empty and full cases first. Random traffic in push-heavy and
// pop-heavy stretches follows, under changing idle rates and one long receive
// stall.
// ----------------------------------------------------------------------------
module double_ended_queue_unit_tb;

  localparam int DEPTH        = 16;
  localparam int RANDOM_ITEMS = 142;

  logic          clk      = 1'b0;
  logic          rst_n    = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  deq_pkg::in_t  in_data  = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  deq_pkg::out_t out_data;

  // Requests waiting for the driver, and results the block still owes.
  deq_pkg::in_t  request_backlog[$];
  deq_pkg::out_t awaited_results[$];

  // Predicted deque contents.
  logic signed [31:0] deq_ring[DEPTH];
  int                 deq_front = 0;
  int                 deq_count = 0;

  int queued_cnt    = 0;
  int accepted_cnt  = 0;
  int mismatches    = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic recv_hold   = 1'b0;

  double_ended_queue_unit #(.DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #4 clk = ~clk;

  // Work out what one accepted request must produce and update the deque.
  task automatic predict_deque_request(input deq_pkg::in_t req);
    deq_pkg::out_t res;
    int            pos;
    res = '0;
    res.last = 1'b1;
    case (req.mode)
      deq_pkg::MODE_PUSH_FRONT, deq_pkg::MODE_PUSH_REAR: begin
        if (deq_count >= DEPTH) begin
          res.status = deq_pkg::STAT_FULL;
        end else begin
          if (req.mode == deq_pkg::MODE_PUSH_FRONT) begin
            deq_front = (deq_front + DEPTH - 1) % DEPTH;
            pos = deq_front;
          end else begin
            pos = (deq_front + deq_count) % DEPTH;
          end
          deq_ring[pos] = req.push_value;
          deq_count++;
          res.status = deq_pkg::STAT_OK;
        end
        awaited_results.push_back(res);
      end
      deq_pkg::MODE_POP_FRONT, deq_pkg::MODE_POP_REAR: begin
        if (deq_count == 0) begin
          res.status = deq_pkg::STAT_EMPTY;
        end else begin
          if (req.mode == deq_pkg::MODE_POP_FRONT) begin
            res.out_value = deq_ring[deq_front];
            deq_front = (deq_front + 1) % DEPTH;
          end else begin
            res.out_value = deq_ring[(deq_front + deq_count - 1) % DEPTH];
          end
          deq_count--;
          res.status = deq_pkg::STAT_OK;
        end
        awaited_results.push_back(res);
      end
      deq_pkg::MODE_LIST: begin
        if (deq_count == 0) begin
          res.status = deq_pkg::STAT_EMPTY;
          awaited_results.push_back(res);
        end else begin
          for (int i = 0; i < deq_count; i++) begin
            res.status    = deq_pkg::STAT_OK;
            res.out_value = deq_ring[(deq_front + i) % DEPTH];
            res.last      = (i == deq_count - 1);
            awaited_results.push_back(res);
          end
        end
      end
      default: begin
        // Undefined modes are swallowed without a result.
      end
    endcase
  endtask

  // Compare one delivered result with the oldest one owed.
  task automatic check_result(input deq_pkg::out_t got);
    deq_pkg::out_t want;
    if (awaited_results.size() == 0) begin
      $error("result with none owed: status %0d value %0d last %0d",
             got.status, got.out_value, got.last);
      mismatches++;
    end else begin
      want = awaited_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.out_value !== want.out_value) begin
        $error("out_value: expected %0d, got %0d", want.out_value, got.out_value);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        mismatches++;
      end
    end
  endtask

  task automatic queue_request(input logic [2:0] mode, input logic signed [31:0] value);
    deq_pkg::in_t req;
    req.mode       = mode;
    req.push_value = value;
    request_backlog.push_back(req);
    queued_cnt++;
  endtask

  // Mostly random values, with the extremes mixed in.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(15))
      0: pick_value = 32'sh7FFF_FFFF;
      1: pick_value = 32'sh8000_0000;
      2: pick_value = '0;
      3: pick_value = -32'sd1;
      default: pick_value = $urandom;
    endcase
  endfunction

  // One random phase; push-heavy and pop-heavy stretches alternate so the
  // deque keeps swinging between empty and full.
  task automatic queue_random_phase(input int count);
    int sent;
    int push_pct;
    sent = 0;
    while (sent < count) begin
      push_pct = ((sent / 24) % 2 == 0) ? 70 : 25;
      if ($urandom_range(99) < 3) begin
        queue_request(3'($urandom_range(7, deq_pkg::MODE_LIST + 1)), pick_value());
      end else begin
        if ($urandom_range(99) < 10) begin
          queue_request(deq_pkg::MODE_LIST, pick_value());
        end else if ($urandom_range(99) < push_pct) begin
          queue_request($urandom_range(1) ? deq_pkg::MODE_PUSH_REAR
                                          : deq_pkg::MODE_PUSH_FRONT, pick_value());
        end else begin
          queue_request($urandom_range(1) ? deq_pkg::MODE_POP_REAR
                                          : deq_pkg::MODE_POP_FRONT, pick_value());
        end
        sent++;
      end
    end
  endtask

  task automatic wait_until_drained();
    wait (accepted_cnt == queued_cnt);
    wait (awaited_results.size() == 0);
  endtask

  // Driver: presents the next backlog request when the slot is free, idling at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= request_backlog.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: checks results, then predicts for the request taken this edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        check_result(out_data);
      end
      if (in_valid && in_ready) begin
        predict_deque_request(in_data);
        accepted_cnt <= accepted_cnt + 1;
      end
    end
  end

  // Long receive stall while the driver keeps offering requests.
  initial begin
    wait (accepted_cnt >= 80);
    @(posedge clk);
    recv_hold <= 1'b1;
    repeat (400) @(posedge clk);
    recv_hold <= 1'b0;
  end

  // Stimulus and end of run.
  initial begin
    repeat (7) @(posedge clk);
    rst_n         <= 1'b1;
    send_idle_pct <= 25;
    recv_idle_pct <= 58;

    // Empty deque: list and both pops report empty; undefined modes vanish.
    queue_request(deq_pkg::MODE_LIST, 32'sd5);
    queue_request(deq_pkg::MODE_POP_FRONT, 32'sd6);
    queue_request(deq_pkg::MODE_POP_REAR, 32'sd7);
    queue_request(3'd5, 32'sh7FFF_FFFF);
    queue_request(3'd6, 32'sh8000_0000);
    queue_request(3'd7, -32'sd1);
    // Extremes in both ends, listed and popped back out.
    queue_request(deq_pkg::MODE_PUSH_FRONT, 32'sh7FFF_FFFF);
    queue_request(deq_pkg::MODE_PUSH_REAR, 32'sh8000_0000);
    queue_request(deq_pkg::MODE_LIST, '0);
    queue_request(deq_pkg::MODE_POP_REAR, '0);
    queue_request(deq_pkg::MODE_POP_FRONT, '0);
    // Fill to capacity so the ring wraps, then push into a full deque.
    for (int i = 0; i < DEPTH; i++) begin
      queue_request((i % 2) ? deq_pkg::MODE_PUSH_REAR : deq_pkg::MODE_PUSH_FRONT,
                    pick_value());
    end
    queue_request(deq_pkg::MODE_PUSH_FRONT, -32'sd1);
    queue_request(deq_pkg::MODE_PUSH_REAR, '0);
    queue_request(deq_pkg::MODE_LIST, '0);

    queue_random_phase(RANDOM_ITEMS);
    wait_until_drained();

    @(posedge clk);
    send_idle_pct <= 58;
    recv_idle_pct <= 25;
    queue_random_phase(RANDOM_ITEMS);
    wait_until_drained();

    @(posedge clk);
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    queue_random_phase(RANDOM_ITEMS);
    wait_until_drained();

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("double_ended_queue_unit_tb: clean");
    end else begin
      $display("double_ended_queue_unit_tb: errors");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #5ms;
    $display("double_ended_queue_unit_tb: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/deq_pkg.sv
hdl/deq_dpath.sv
hdl/deq_ctrl.sv
hdl/double_ended_queue_unit.sv
verif/double_ended_queue_unit_tb.sv
